// ===== hw/rtl/brb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command and status codes, and sequencer states of the byte ring buffer.
package brb_pkg;

    localparam int DEPTH_DEF = 4096;
    localparam int BYTE_W    = 8;
    localparam int CNT_OUT_W = 13;

    localparam logic [3:0] NB_MAX = 4'd8;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_PEEK   = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_SKIP   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADDR,
        S_WR,
        S_RD,
        S_RDL,
        S_DROP,
        S_OUT
    } brb_state_t;

endpackage

// ===== hw/rtl/byte_ring_buffer_big_endian_access.sv =====
`timescale 1ns / 1ps
// Top level: command sequencer of the byte ring buffer with big-endian integer access.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid/in_stall    func num_bytes offset value skip_count
//   out      from block out_valid/out_stall  data readable writable status
//
// One command at a time; in_stall is high from acceptance until the result is taken.
// Append checks space, sets the address, then writes one byte a cycle through the single byte
// port of the store; peek and read fetch bytes the same way, and read then drops them; skip moves
// the pointers, clear resets them, and errors and zero-size transfers go straight to the result.
// Reset clears the read pointer and fill count; stored bytes stay undefined until written.
// A stalled result holds out_valid and all result ports.
module byte_ring_buffer_big_endian_access #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [3:0]  num_bytes,
    input  logic [11:0] offset,
    input  logic [63:0] value,
    input  logic [12:0] skip_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data,
    output logic [12:0] readable,
    output logic [12:0] writable,
    output logic [1:0]  status
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > CNT_OUT_W) ? CW : CNT_OUT_W) + 1;

    brb_state_t state_reg, state_next;

    logic [2:0]        func_reg;
    logic [3:0]        nb_reg;
    logic [11:0]       off_reg;
    logic [63:0]       value_reg;
    logic [12:0]       skip_reg;
    logic [3:0]        cnt_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     rp_reg;
    logic [CW-1:0]     fill_reg;
    logic [63:0]       data_reg;
    logic [1:0]        status_reg;
    logic              pend_reg;

    logic [CW-1:0]     free;
    logic [SW-1:0]     alu_a;
    logic [SW-1:0]     alu_b;
    logic              alu_lt;
    logic [AW-1:0]     alu_wrap;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    logic [2:0]        byte_idx;
    logic              known_op;

    assign free      = CW'(DEPTH) - fill_reg;
    assign byte_idx  = 3'(cnt_reg - 4'd1);
    assign mem_addr  = addr_reg;
    assign mem_wdata = value_reg[{byte_idx, 3'b000} +: BYTE_W];
    assign known_op  = (func_reg == OP_APPEND) || (func_reg == OP_PEEK)
                    || (func_reg == OP_READ) || (func_reg == OP_SKIP);

    brb_alu #(
        .DEPTH (DEPTH),
        .SW    (SW)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .lt   (alu_lt),
        .wrap (alu_wrap)
    );

    brb_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!known_op || alu_lt)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (func_reg == OP_SKIP || nb_reg == 4'd0)
                begin
                    state_next = S_OUT;
                end
                else if (func_reg == OP_APPEND)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_WR:
            begin
                if (cnt_reg == 4'd1)
                begin
                    state_next = S_OUT;
                end
            end
            S_RD:
            begin
                if (cnt_reg == 4'd1)
                begin
                    state_next = S_RDL;
                end
            end
            S_RDL:
            begin
                state_next = (func_reg == OP_READ) ? S_DROP : S_OUT;
            end
            S_DROP:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_OUT);
        mem_we    = (state_reg == S_WR);
        alu_a     = '0;
        alu_b     = '0;
        unique case (state_reg)
            S_CHECK:
            begin
                case (func_reg)
                    OP_APPEND:
                    begin
                        alu_a = SW'(free);
                        alu_b = SW'(nb_reg);
                    end
                    OP_PEEK:
                    begin
                        alu_a = SW'(fill_reg);
                        alu_b = SW'(off_reg) + SW'(nb_reg);
                    end
                    OP_READ:
                    begin
                        alu_a = SW'(fill_reg);
                        alu_b = SW'(nb_reg);
                    end
                    OP_SKIP:
                    begin
                        alu_a = SW'(fill_reg);
                        alu_b = SW'(skip_reg);
                    end
                    default:
                    begin
                        alu_a = '0;
                        alu_b = '0;
                    end
                endcase
            end
            S_ADDR:
            begin
                alu_a = SW'(rp_reg);
                case (func_reg)
                    OP_APPEND: alu_b = SW'(fill_reg);
                    OP_PEEK:   alu_b = SW'(off_reg);
                    OP_SKIP:   alu_b = SW'(skip_reg);
                    default:   alu_b = '0;
                endcase
            end
            S_WR, S_RD:
            begin
                alu_a = SW'(addr_reg);
                alu_b = SW'(1);
            end
            S_DROP:
            begin
                alu_a = SW'(rp_reg);
                alu_b = SW'(nb_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg    <= '0;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                end
                S_CHECK:
                begin
                    if (func_reg == OP_CLEAR)
                    begin
                        rp_reg   <= '0;
                        fill_reg <= '0;
                    end
                end
                S_ADDR:
                begin
                    if (func_reg == OP_SKIP)
                    begin
                        rp_reg   <= alu_wrap;
                        fill_reg <= fill_reg - CW'(skip_reg);
                    end
                end
                S_WR:
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
                S_RD:
                begin
                    pend_reg <= 1'b1;
                end
                S_RDL:
                begin
                    pend_reg <= 1'b0;
                end
                S_DROP:
                begin
                    rp_reg   <= alu_wrap;
                    fill_reg <= fill_reg - CW'(nb_reg);
                end
                default:
                begin
                    pend_reg <= pend_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_reg   <= func;
                    nb_reg     <= (num_bytes > NB_MAX) ? NB_MAX : num_bytes;
                    off_reg    <= offset;
                    value_reg  <= value;
                    skip_reg   <= skip_count;
                    data_reg   <= '0;
                    status_reg <= ST_OK;
                end
            end
            S_CHECK:
            begin
                if (known_op && alu_lt)
                begin
                    status_reg <= (func_reg == OP_APPEND) ? ST_FULL : ST_SHORT;
                end
            end
            S_ADDR:
            begin
                addr_reg <= alu_wrap;
                cnt_reg  <= nb_reg;
            end
            S_WR:
            begin
                addr_reg <= alu_wrap;
                cnt_reg  <= cnt_reg - 4'd1;
            end
            S_RD:
            begin
                addr_reg <= alu_wrap;
                cnt_reg  <= cnt_reg - 4'd1;
                if (pend_reg)
                begin
                    data_reg <= {data_reg[55:0], mem_rdata};
                end
            end
            S_RDL:
            begin
                data_reg <= {data_reg[55:0], mem_rdata};
            end
            default:
            begin
                data_reg <= data_reg;
            end
        endcase
    end

    assign data     = data_reg;
    assign status   = status_reg;
    assign readable = CNT_OUT_W'(fill_reg);
    assign writable = CNT_OUT_W'(free);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> data == 64'd0)
        else $error("error transaction carries data");

    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK && known_op && alu_lt |=>
            $stable(fill_reg) && $stable(rp_reg))
        else $error("failed command changed pointer or fill");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(fill_reg) && $stable(rp_reg) && out_valid)
        else $error("state moved while result stalled");

endmodule

// ===== hw/rtl/brb_ram.sv =====
`timescale 1ns / 1ps
// Byte store of the ring buffer: one write or read per cycle, registered read data.
module brb_ram #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          addr,
    input  logic [brb_pkg::BYTE_W-1:0]        wdata,
    output logic [brb_pkg::BYTE_W-1:0]        rdata
);
    import brb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/brb_alu.sv =====
`timescale 1ns / 1ps
// Shared add-with-ring-wrap and less-than unit used by the check, address, transfer and drop steps.
module brb_alu #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF,
    parameter int SW    = 14
) (
    input  logic [SW-1:0]            a,
    input  logic [SW-1:0]            b,
    output logic                     lt,
    output logic [$clog2(DEPTH)-1:0] wrap
);
    localparam int AW = $clog2(DEPTH);

    logic [SW:0] sum;
    logic [SW:0] sum_wrap;

    always_comb
    begin
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SW+1)'(DEPTH))
        begin
            sum_wrap = sum - (SW+1)'(DEPTH);
        end
        else
        begin
            sum_wrap = sum;
        end
    end

    assign wrap = sum_wrap[AW-1:0];
    assign lt   = (a < b);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking byte ring buffer bench: directed, capacity, backpressure, back-to-back and random tests.
module tb_top;
    import brb_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int RANDOM_ITEMS   = 60;
    localparam int BURST_ITEMS    = 20;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [63:0] data;
        logic [12:0] readable;
        logic [12:0] writable;
        logic [1:0]  status;
    } ring_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [3:0]  num_bytes;
    logic [11:0] offset;
    logic [63:0] value;
    logic [12:0] skip_count;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] data;
    logic [12:0] readable;
    logic [12:0] writable;
    logic [1:0]  status;

    logic [7:0]   ring_mirror [DEPTH];
    logic [11:0]  mirror_rd;
    int unsigned  mirror_fill;
    ring_result_t expected_results [$];
    int           errors;
    logic         no_idle;
    logic         long_hold_req;

    byte_ring_buffer_big_endian_access DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .num_bytes  (num_bytes),
        .offset     (offset),
        .value      (value),
        .skip_count (skip_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data       (data),
        .readable   (readable),
        .writable   (writable),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] gather_bytes(input int unsigned start_off,
                                                 input int unsigned count);
        logic [63:0] acc;
        int unsigned i;
        acc = '0;
        for (i = 0; i < count; i++)
            acc = {acc[55:0], ring_mirror[(mirror_rd + start_off + i) % DEPTH]};
        return acc;
    endfunction

    function automatic void drop_bytes(input int unsigned count);
        mirror_rd   = 12'((mirror_rd + count) % DEPTH);
        mirror_fill = mirror_fill - count;
    endfunction

    function automatic ring_result_t predict_command(input logic [2:0] f,
                                                     input logic [3:0] nb_in,
                                                     input logic [11:0] off,
                                                     input logic [63:0] val,
                                                     input logic [12:0] skip);
        ring_result_t r;
        int unsigned  nb;
        int unsigned  i;
        r        = '0;
        r.status = ST_OK;
        nb       = (nb_in > NB_MAX) ? NB_MAX : nb_in;
        case (f)
            OP_APPEND:
            begin
                if (DEPTH - mirror_fill < nb)
                    r.status = ST_FULL;
                else
                    for (i = 1; i <= nb; i++)
                    begin
                        ring_mirror[(mirror_rd + mirror_fill) % DEPTH] = 8'(val >> ((nb - i) * 8));
                        mirror_fill++;
                    end
            end
            OP_PEEK:
            begin
                if (mirror_fill < off + nb)
                    r.status = ST_SHORT;
                else
                    r.data = gather_bytes(off, nb);
            end
            OP_READ:
            begin
                if (mirror_fill < nb)
                    r.status = ST_SHORT;
                else
                begin
                    r.data = gather_bytes(0, nb);
                    drop_bytes(nb);
                end
            end
            OP_SKIP:
            begin
                if (mirror_fill < skip)
                    r.status = ST_SHORT;
                else
                    drop_bytes(skip);
            end
            OP_CLEAR:
            begin
                mirror_rd   = '0;
                mirror_fill = 0;
            end
            default:
            begin
            end
        endcase
        r.readable = 13'(mirror_fill);
        r.writable = 13'(DEPTH - mirror_fill);
        return r;
    endfunction

    task automatic send_command(input logic [2:0] f, input logic [3:0] nb,
                                input logic [11:0] off, input logic [63:0] val,
                                input logic [12:0] skip);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        num_bytes  <= nb;
        offset     <= off;
        value      <= val;
        skip_count <= skip;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_results.push_back(predict_command(f, nb, off, val, skip));
    endtask

    task automatic send_random_command();
        logic [2:0]  f;
        logic [3:0]  nb;
        logic [11:0] off;
        logic [12:0] skip;
        logic [63:0] val;
        int          r;
        r    = $urandom_range(0, 99);
        val  = {$urandom, $urandom};
        nb   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        off  = 12'($urandom);
        skip = 13'($urandom);
        if (r < 38)
            f = OP_APPEND;
        else if (r < 60)
            f = OP_READ;
        else if (r < 80)
        begin
            f = OP_PEEK;
            if (r < 77 && mirror_fill > 0)
                off = 12'($urandom_range(0, mirror_fill - 1));
        end
        else if (r < 93)
        begin
            f = OP_SKIP;
            if (r < 91)
                skip = 13'($urandom_range(0, mirror_fill));
        end
        else if (r < 96)
            f = OP_CLEAR;
        else
            f = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        send_command(f, nb, off, val, skip);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_command(OP_READ, 4'd1, 12'd0, 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd0, 12'd0, 64'd0, 13'd0);
        send_command(OP_SKIP, 4'd0, 12'd0, 64'd0, 13'd0);
        send_command(OP_SKIP, 4'd0, 12'd0, 64'd0, 13'd1);
        send_command(OP_APPEND, 4'd0, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0);
        send_command(OP_APPEND, 4'd8, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0);
        send_command(OP_APPEND, 4'd1, 12'd0, 64'd0, 13'd0);
        send_command(OP_APPEND, 4'hF, 12'd0, 64'h0123_4567_89AB_CDEF, 13'd0);
        send_command(OP_APPEND, 4'd3, 12'd0, 64'h1122_3344_55A5_C35A, 13'd0);
        send_command(OP_PEEK, 4'd4, 12'd6, 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd1, 12'd19, 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd2, 12'd19, 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd8, 12'hFFF, 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd0, 12'd20, 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd0, 12'd21, 64'd0, 13'd0);
        send_command(OP_READ, 4'd9, 12'd0, 64'd0, 13'd0);
        send_command(OP_READ, 4'd0, 12'd0, 64'd0, 13'd0);
        send_command(OP_SKIP, 4'd0, 12'd0, 64'd0, 13'd3);
        send_command(OP_SKIP, 4'd0, 12'd0, 64'd0, 13'h1FFF);
        send_command(OP_SPARE_LO, 4'd8, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 13'd1);
        send_command(OP_SPARE_LO + 3'd1, 4'd1, 12'd0, 64'd0, 13'd0);
        send_command(OP_SPARE_HI, 4'hF, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 13'h1FFF);
        send_command(OP_READ, 4'd8, 12'd0, 64'd0, 13'd0);
        send_command(OP_CLEAR, 4'd0, 12'd0, 64'd0, 13'd0);
        send_command(OP_READ, 4'd1, 12'd0, 64'd0, 13'd0);
    endtask

    task automatic test_capacity();
        send_command(OP_CLEAR, 4'd0, 12'd0, 64'd0, 13'd0);
        repeat (DEPTH / 8)
            send_command(OP_APPEND, 4'd8, 12'($urandom), {$urandom, $urandom}, 13'($urandom));
        send_command(OP_APPEND, 4'd1, 12'd0, {$urandom, $urandom}, 13'd0);
        send_command(OP_APPEND, 4'd0, 12'd0, {$urandom, $urandom}, 13'd0);
        send_command(OP_PEEK, 4'd8, 12'(DEPTH - 8), 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd1, 12'(DEPTH - 1), 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd2, 12'(DEPTH - 1), 64'd0, 13'd0);
        send_command(OP_SKIP, 4'd0, 12'd0, 64'd0, 13'd100);
        repeat (12)
            send_command(OP_APPEND, 4'd8, 12'd0, {$urandom, $urandom}, 13'd0);
        send_command(OP_APPEND, 4'd4, 12'd0, {$urandom, $urandom}, 13'd0);
        send_command(OP_APPEND, 4'd1, 12'd0, {$urandom, $urandom}, 13'd0);
        send_command(OP_PEEK, 4'd8, 12'(DEPTH - 8), 64'd0, 13'd0);
        send_command(OP_PEEK, 4'd8, 12'(DEPTH - 106 - 3), 64'd0, 13'd0);
        send_command(OP_SKIP, 4'd0, 12'd0, 64'd0, 13'(DEPTH));
        send_command(OP_READ, 4'd1, 12'd0, 64'd0, 13'd0);
    endtask

    task automatic test_backpressure();
        repeat (6)
            send_command(OP_APPEND, 4'($urandom_range(1, 8)), 12'd0, {$urandom, $urandom}, 13'd0);
        long_hold_req = 1'b1;
        repeat (10)
            send_random_command();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (BURST_ITEMS)
            send_random_command();
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        repeat (RANDOM_ITEMS)
            send_random_command();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual data %0h status %0d",
                             $time, data, status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("data", want.data, data);
                check_field("readable", 64'(want.readable), 64'(readable));
                check_field("writable", 64'(want.writable), 64'(writable));
                check_field("status", 64'(want.status), 64'(status));
            end
        end
    end

    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap();
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0)
                || (out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[byte_ring_buffer_big_endian_access] ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = OP_APPEND;
        num_bytes     = '0;
        offset        = '0;
        value         = '0;
        skip_count    = '0;
        errors        = 0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        mirror_rd     = '0;
        mirror_fill   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_back_to_back();
        test_random();
        wait_drained();

        if (errors == 0)
            $display("[byte_ring_buffer_big_endian_access] OK");
        else
            $display("[byte_ring_buffer_big_endian_access] ERROR");
        $finish;
    end

endmodule
